// ===== rtl/jrcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jrcd_pkg
// shared types, codes, property tables and record builders for the join
// reorder conflict detector
// ----------------------------------------------------------------------------
package jrcd_pkg;

    localparam int FIELD_W = 32;

    typedef enum logic [1:0] {
        ITEM_CLEAR = 2'd0,
        ITEM_LOAD  = 2'd1,
        ITEM_QUERY = 2'd2,
        ITEM_NONE  = 2'd3
    } item_kind_t;

    typedef enum logic [2:0] {
        CAT_JOIN   = 3'd0,
        CAT_LOUTER = 3'd1,
        CAT_FOUTER = 3'd2,
        CAT_SEMI   = 3'd3,
        CAT_ANTI   = 3'd4
    } cat_t;

    // join kind codes
    localparam logic [2:0] JK_INNER = 3'd0;
    localparam logic [2:0] JK_LEFT  = 3'd1;
    localparam logic [2:0] JK_RIGHT = 3'd2;
    localparam logic [2:0] JK_FULL  = 3'd3;
    localparam logic [2:0] JK_CROSS = 3'd4;
    localparam logic [2:0] JK_COMMA = 3'd5;

    // strictness codes
    localparam logic [1:0] ST_ALL  = 2'd0;
    localparam logic [1:0] ST_SEMI = 2'd1;
    localparam logic [1:0] ST_ANTI = 2'd2;

    // property tables, row = upper operator category, bit = lower category
    localparam logic [4:0] ASSOC_TAB [5] = '{
        5'b11011, 5'b00000, 5'b00000, 5'b00000, 5'b00000
    };
    localparam logic [4:0] LASSCOM_TAB [5] = '{
        5'b11011, 5'b11011, 5'b00000, 5'b11011, 5'b11011
    };
    localparam logic [4:0] RASSCOM_TAB [5] = '{
        5'b00001, 5'b00000, 5'b00000, 5'b00000, 5'b00000
    };

    typedef struct packed {
        logic               record_type;
        logic [FIELD_W-1:0] op_relations;
        logic [FIELD_W-1:0] op_left_relations;
        logic [FIELD_W-1:0] req_left;
        logic [FIELD_W-1:0] req_right;
        logic [FIELD_W-1:0] pred_rels_out;
        logic [2:0]         norm_kind;
        logic [1:0]         norm_strictness;
        logic               free_reorder;
        logic [FIELD_W-1:0] rule_trigger;
        logic [FIELD_W-1:0] rule_target;
    } rec_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic b_start;
        logic b_cap;
        logic walk;
        logic emit;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_ok;
        logic slot_hit;
        logic cdc;
        logic rule_hit;
        logic idx_last;
        logic idx_done;
        logic two_rules;
        logic out_free;
    } dp_status_t;

    function automatic logic assoc_ok(cat_t rc, cat_t cc, logic rn, logic cn);
        logic ok;
        if (ASSOC_TAB[rc][cc]) begin
            ok = 1'b1;
        end else if ((rc == CAT_LOUTER || rc == CAT_FOUTER) && cc == CAT_LOUTER) begin
            ok = cn;
        end else if (rc == CAT_FOUTER && cc == CAT_FOUTER) begin
            ok = rn & cn;
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic lasscom_ok(cat_t rc, cat_t cc, logic rn_e1, logic cn_e1,
                                        logic cn_e3);
        logic ok;
        if (LASSCOM_TAB[rc][cc]) begin
            ok = 1'b1;
        end else if (rc == CAT_LOUTER && cc == CAT_FOUTER) begin
            ok = rn_e1;
        end else if (rc == CAT_FOUTER && cc == CAT_LOUTER) begin
            ok = cn_e3;
        end else if (rc == CAT_FOUTER && cc == CAT_FOUTER) begin
            ok = rn_e1 & cn_e1;
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic rasscom_ok(cat_t rc, cat_t cc, logic rn_e3, logic cn_e3);
        logic ok;
        if (RASSCOM_TAB[rc][cc]) begin
            ok = 1'b1;
        end else if (rc == CAT_FOUTER && cc == CAT_FOUTER) begin
            ok = rn_e3 & cn_e3;
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic rec_t make_desc(logic [FIELD_W-1:0] l, logic [FIELD_W-1:0] r,
                                       logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] req,
                                       logic [2:0] kind, logic [1:0] strict, cat_t cat);
        rec_t d;
        d                   = '0;
        d.record_type       = 1'b0;
        d.op_relations      = l | r;
        d.op_left_relations = l;
        d.req_left          = req & l;
        d.req_right         = req & r;
        d.pred_rels_out     = p;
        d.norm_kind         = kind;
        d.norm_strictness   = strict;
        d.free_reorder      = (cat == CAT_JOIN);
        return d;
    endfunction

    function automatic rec_t make_rule(logic [FIELD_W-1:0] t1, logic [FIELD_W-1:0] t2);
        rec_t d;
        d              = '0;
        d.record_type  = 1'b1;
        d.rule_trigger = t1;
        d.rule_target  = t2;
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/jrcd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jrcd_datapath
// operator table memory, normalization, per-slot conflict checks, rule
// holding registers and the output register
// ----------------------------------------------------------------------------
module jrcd_datapath #(
    parameter int MAX_OPS   = 16,
    parameter int REL_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire jrcd_pkg::ctrl_cmd_t        cmd,
    output jrcd_pkg::dp_status_t            status,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_data,
    input  wire logic [3:0]                 s_slot,
    input  wire logic [2:0]                 s_join_kind,
    input  wire logic [1:0]                 s_join_strictness,
    input  wire logic [31:0]                s_left_rels,
    input  wire logic [31:0]                s_right_rels,
    input  wire logic [31:0]                s_pred_rels,
    input  wire logic [31:0]                s_null_reject_rels,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output jrcd_pkg::rec_t                  m_rec,
    output logic                            m_last
);
    import jrcd_pkg::*;

    localparam int SW = (REL_WIDTH < FIELD_W) ? REL_WIDTH : FIELD_W;
    localparam int IW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int CW = $clog2(MAX_OPS + 1);

    // operator table
    cat_t        mem_cat    [MAX_OPS];
    logic [SW-1:0] mem_left [MAX_OPS];
    logic [SW-1:0] mem_right[MAX_OPS];
    logic [SW-1:0] mem_pred [MAX_OPS];
    logic [SW-1:0] mem_nr   [MAX_OPS];
    logic [2:0]  mem_kind   [MAX_OPS];
    logic [1:0]  mem_strict [MAX_OPS];

    cat_t          rd_cat_reg;
    logic [SW-1:0] rd_left_reg, rd_right_reg, rd_pred_reg, rd_nr_reg;
    logic [2:0]    rd_kind_reg;
    logic [1:0]    rd_strict_reg;

    logic [MAX_OPS-1:0] valid_reg;
    logic               mode_reg;

    // queried operator
    logic [IW-1:0] bidx_reg;
    cat_t          b_cat_reg;
    logic [SW-1:0] b_left_reg, b_right_reg, b_pred_reg, b_nr_reg;
    logic [2:0]    b_kind_reg;
    logic [1:0]    b_strict_reg;
    logic [SW-1:0] tes_reg;

    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] rd_addr;

    logic          r1_v_reg, r2_v_reg;
    logic [SW-1:0] r1_t1_reg, r1_t2_reg, r2_t1_reg, r2_t2_reg;

    rec_t          pend_reg, out_rec_reg;
    logic          out_last_reg, m_valid_reg;

    logic [5:0]    slot_ext;
    logic [IW-1:0] slot_idx;

    // load normalization
    logic [2:0]    jk, nk;
    logic [1:0]    ns;
    cat_t          ncat;
    logic          swap;
    logic [SW-1:0] in_l, in_r;

    // walk evaluation
    logic [IW-1:0] a_idx;
    logic          a_live, in_left, in_right;
    logic [SW-1:0] arel, al_n, ar_n;
    logic          c1, c2, f1, f2;
    logic [SW-1:0] w1, w2, t11, t12, t21, t22;

    assign slot_ext = 6'(s_slot);
    assign slot_idx = slot_ext[IW-1:0];
    assign in_l     = s_left_rels[SW-1:0];
    assign in_r     = s_right_rels[SW-1:0];

    always_comb begin
        jk   = (s_join_kind > JK_COMMA) ? JK_INNER : s_join_kind;
        swap = 1'b0;
        ns   = ST_ALL;
        if (s_join_strictness == ST_SEMI || s_join_strictness == ST_ANTI) begin
            ncat = (s_join_strictness == ST_SEMI) ? CAT_SEMI : CAT_ANTI;
            swap = (jk == JK_RIGHT);
            nk   = JK_LEFT;
            ns   = s_join_strictness;
        end else if (jk == JK_LEFT || jk == JK_RIGHT) begin
            ncat = CAT_LOUTER;
            swap = (jk == JK_RIGHT);
            nk   = JK_LEFT;
        end else if (jk == JK_FULL) begin
            ncat = CAT_FOUTER;
            nk   = JK_FULL;
        end else begin
            ncat = CAT_JOIN;
            nk   = jk;
        end
    end

    always_comb begin
        if (cmd.b_cap) begin
            idx_next = '0;
        end else if (cmd.walk) begin
            idx_next = idx_reg + CW'(1);
        end else begin
            idx_next = idx_reg;
        end
        rd_addr = cmd.b_start ? slot_idx : idx_next[IW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem_cat[slot_idx]    <= ncat;
            mem_left[slot_idx]   <= swap ? in_r : in_l;
            mem_right[slot_idx]  <= swap ? in_l : in_r;
            mem_pred[slot_idx]   <= s_pred_rels[SW-1:0];
            mem_nr[slot_idx]     <= s_null_reject_rels[SW-1:0];
            mem_kind[slot_idx]   <= nk;
            mem_strict[slot_idx] <= ns;
        end
        rd_cat_reg    <= mem_cat[rd_addr];
        rd_left_reg   <= mem_left[rd_addr];
        rd_right_reg  <= mem_right[rd_addr];
        rd_pred_reg   <= mem_pred[rd_addr];
        rd_nr_reg     <= mem_nr[rd_addr];
        rd_kind_reg   <= mem_kind[rd_addr];
        rd_strict_reg <= mem_strict[rd_addr];
    end

    // checks of the slot under the walk against the queried operator
    always_comb begin
        a_idx    = idx_reg[IW-1:0];
        a_live   = valid_reg[a_idx] && (a_idx != bidx_reg);
        arel     = rd_left_reg | rd_right_reg;
        in_left  = ((arel & ~b_left_reg) == '0);
        in_right = ((arel & ~b_right_reg) == '0);
        al_n     = ((rd_left_reg & rd_pred_reg) != '0) ? (rd_left_reg & rd_pred_reg)
                                                        : rd_left_reg;
        ar_n     = ((rd_right_reg & rd_pred_reg) != '0) ? (rd_right_reg & rd_pred_reg)
                                                         : rd_right_reg;
        c1 = 1'b0;
        c2 = 1'b0;
        w1 = rd_left_reg;
        w2 = rd_right_reg;
        t11 = rd_right_reg;
        t12 = al_n;
        t21 = rd_left_reg;
        t22 = ar_n;
        if (in_left) begin
            c1 = !assoc_ok(rd_cat_reg, b_cat_reg, |(rd_nr_reg & rd_right_reg),
                           |(b_nr_reg & rd_right_reg));
            c2 = !lasscom_ok(rd_cat_reg, b_cat_reg, |(rd_nr_reg & rd_left_reg),
                             |(b_nr_reg & rd_left_reg), |(b_nr_reg & b_right_reg));
        end else if (in_right) begin
            c1 = !assoc_ok(b_cat_reg, rd_cat_reg, |(b_nr_reg & rd_left_reg),
                           |(rd_nr_reg & rd_left_reg));
            c2 = !rasscom_ok(b_cat_reg, rd_cat_reg, |(b_nr_reg & rd_right_reg),
                             |(rd_nr_reg & rd_right_reg));
            w1  = rd_right_reg;
            w2  = rd_left_reg;
            t11 = rd_left_reg;
            t12 = ar_n;
            t21 = rd_right_reg;
            t22 = al_n;
        end
        f1 = a_live & c1;
        f2 = a_live & c2;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            mode_reg    <= 1'b0;
            idx_reg     <= '0;
            r1_v_reg    <= 1'b0;
            r2_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_data;
            end
            if (cmd.clear) begin
                valid_reg <= '0;
            end else if (cmd.load) begin
                valid_reg[slot_idx] <= 1'b1;
            end
            idx_reg <= idx_next;
            if (cmd.walk) begin
                r1_v_reg <= mode_reg & f1;
                r2_v_reg <= mode_reg & f2;
            end else if (cmd.emit) begin
                if (r1_v_reg) begin
                    r1_v_reg <= 1'b0;
                end else begin
                    r2_v_reg <= 1'b0;
                end
            end
            if (cmd.emit || cmd.flush) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.b_start) begin
            bidx_reg <= slot_idx;
        end
        if (cmd.b_cap) begin
            b_cat_reg    <= rd_cat_reg;
            b_left_reg   <= rd_left_reg;
            b_right_reg  <= rd_right_reg;
            b_pred_reg   <= rd_pred_reg;
            b_nr_reg     <= rd_nr_reg;
            b_kind_reg   <= rd_kind_reg;
            b_strict_reg <= rd_strict_reg;
            tes_reg      <= rd_pred_reg & (rd_left_reg | rd_right_reg);
            pend_reg     <= make_desc(FIELD_W'(rd_left_reg), FIELD_W'(rd_right_reg),
                                      FIELD_W'(rd_pred_reg),
                                      FIELD_W'(rd_pred_reg & (rd_left_reg | rd_right_reg)),
                                      rd_kind_reg, rd_strict_reg, rd_cat_reg);
        end
        if (cmd.walk) begin
            tes_reg   <= tes_reg | (f1 ? w1 : '0) | (f2 ? w2 : '0);
            r1_t1_reg <= t11;
            r1_t2_reg <= t12;
            r2_t1_reg <= t21;
            r2_t2_reg <= t22;
        end
        if (cmd.emit) begin
            out_rec_reg  <= pend_reg;
            out_last_reg <= 1'b0;
            pend_reg     <= r1_v_reg ? make_rule(FIELD_W'(r1_t1_reg), FIELD_W'(r1_t2_reg))
                                     : make_rule(FIELD_W'(r2_t1_reg), FIELD_W'(r2_t2_reg));
        end else if (cmd.flush) begin
            out_rec_reg  <= mode_reg ? pend_reg
                          : make_desc(FIELD_W'(b_left_reg), FIELD_W'(b_right_reg),
                                      FIELD_W'(b_pred_reg), FIELD_W'(tes_reg),
                                      b_kind_reg, b_strict_reg, b_cat_reg);
            out_last_reg <= 1'b1;
        end
    end

    always_comb begin
        status.slot_ok   = (slot_ext < 6'(MAX_OPS));
        status.slot_hit  = valid_reg[slot_idx];
        status.cdc       = mode_reg;
        status.rule_hit  = f1 | f2;
        status.idx_last  = (idx_reg == CW'(MAX_OPS - 1));
        status.idx_done  = (idx_reg == CW'(MAX_OPS));
        status.two_rules = r1_v_reg & r2_v_reg;
        status.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_rec   = out_rec_reg;
    assign m_last  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/jrcd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jrcd_ctrl
// sequencer: takes input words, walks the operator table for a query and
// paces rule and descriptor output
// ----------------------------------------------------------------------------
module jrcd_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_kind,
    input  wire jrcd_pkg::dp_status_t  status,
    output jrcd_pkg::ctrl_cmd_t        cmd
);
    import jrcd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BCAP  = 5'b00010,
        S_WALK  = 5'b00100,
        S_RULE  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    item_kind_t item;

    assign item = item_kind_t'(s_kind);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (item)
                        ITEM_CLEAR: cmd.clear = 1'b1;
                        ITEM_LOAD:  cmd.load  = status.slot_ok;
                        ITEM_QUERY: begin
                            if (status.slot_ok && status.slot_hit) begin
                                cmd.b_start = 1'b1;
                                state_next  = S_BCAP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_BCAP: begin
                cmd.b_cap  = 1'b1;
                state_next = S_WALK;
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (status.cdc && status.rule_hit) begin
                    state_next = S_RULE;
                end else if (status.idx_last) begin
                    state_next = S_FLUSH;
                end
            end
            S_RULE: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (!status.two_rules) begin
                        state_next = status.idx_done ? S_FLUSH : S_WALK;
                    end
                end
            end
            S_FLUSH: begin
                if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/join_reorder_conflict_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// join_reorder_conflict_detector
// join operator table with CD-A / CD-C conflict detection
// ----------------------------------------------------------------------------
// A query of a loaded slot reads the slot, then walks all MAX_OPS table
// entries one per cycle through the single read port of the operator
// table, stalling for each conflict rule found in CD-C mode (at most two
// per entry) and for any wait on m_ready. The descriptor always comes
// first; in CD-C mode the rules follow in ascending slot order and m_last
// marks the final word of the query. Queries of empty or out-of-range
// slots, and unknown item kinds, give no output. Results sit in an output
// register, so a new input word is taken while the last result of a query
// still waits. The user must write conflict_mode over the cfg port only
// while the block is idle; the block itself does not enforce it. Masks are
// cut to REL_WIDTH bits.
// ----------------------------------------------------------------------------
module join_reorder_conflict_detector #(
    parameter int MAX_OPS   = 16,
    parameter int REL_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // input words
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [3:0]  s_slot,
    input  wire logic [2:0]  s_join_kind,
    input  wire logic [1:0]  s_join_strictness,
    input  wire logic [31:0] s_left_rels,
    input  wire logic [31:0] s_right_rels,
    input  wire logic [31:0] s_pred_rels,
    input  wire logic [31:0] s_null_reject_rels,
    // result words
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_record_type,
    output logic [31:0]      m_op_relations,
    output logic [31:0]      m_op_left_relations,
    output logic [31:0]      m_req_left,
    output logic [31:0]      m_req_right,
    output logic [31:0]      m_pred_rels_out,
    output logic [2:0]       m_norm_kind,
    output logic [1:0]       m_norm_strictness,
    output logic             m_free_reorder,
    output logic [31:0]      m_rule_trigger,
    output logic [31:0]      m_rule_target,
    output logic             m_last
);
    import jrcd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    rec_t       rec;
    logic       cfg_we;

    // the mode register takes a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    jrcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .status  (status),
        .cmd     (cmd)
    );

    jrcd_datapath #(
        .MAX_OPS   (MAX_OPS),
        .REL_WIDTH (REL_WIDTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_we),
        .cfg_data           (cfg_data),
        .s_slot             (s_slot),
        .s_join_kind        (s_join_kind),
        .s_join_strictness  (s_join_strictness),
        .s_left_rels        (s_left_rels),
        .s_right_rels       (s_right_rels),
        .s_pred_rels        (s_pred_rels),
        .s_null_reject_rels (s_null_reject_rels),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_rec              (rec),
        .m_last             (m_last)
    );

    // unpack the result word onto its ports
    assign m_record_type       = rec.record_type;
    assign m_op_relations      = rec.op_relations;
    assign m_op_left_relations = rec.op_left_relations;
    assign m_req_left          = rec.req_left;
    assign m_req_right         = rec.req_right;
    assign m_pred_rels_out     = rec.pred_rels_out;
    assign m_norm_kind         = rec.norm_kind;
    assign m_norm_strictness   = rec.norm_strictness;
    assign m_free_reorder      = rec.free_reorder;
    assign m_rule_trigger      = rec.rule_trigger;
    assign m_rule_target       = rec.rule_target;

endmodule
`default_nettype wire

// ===== bench/jrcd_check_pkg.sv =====
// ----------------------------------------------------------------------------
// jrcd_check_pkg
// operator-table model and result scoreboard for the join reorder conflict
// detector bench: tracks the loaded operators and queues the expected words
// ----------------------------------------------------------------------------
package jrcd_check_pkg;
    import jrcd_pkg::*;

    localparam int NUM_SLOTS = 16;

    typedef struct packed {
        item_kind_t  kind;
        logic [3:0]  slot;
        logic [2:0]  join_kind;
        logic [1:0]  join_strictness;
        logic [31:0] left_rels;
        logic [31:0] right_rels;
        logic [31:0] pred_rels;
        logic [31:0] null_reject_rels;
    } op_word_t;

    typedef struct packed {
        rec_t rec;
        logic last;
    } out_word_t;

    class conflict_scoreboard;
        bit          cdc_mode;
        bit          loaded [NUM_SLOTS];
        cat_t        category [NUM_SLOTS];
        logic [31:0] left_side [NUM_SLOTS];
        logic [31:0] right_side [NUM_SLOTS];
        logic [31:0] pred_mask [NUM_SLOTS];
        logic [31:0] null_reject [NUM_SLOTS];
        logic [2:0]  out_kind [NUM_SLOTS];
        logic [1:0]  out_strictness [NUM_SLOTS];
        out_word_t   expected_words [$];
        int          mismatches;
        int          words_checked;
        int          rules_predicted;
        int          longest_run;

        function new();
            cdc_mode        = 1'b0;
            mismatches      = 0;
            words_checked   = 0;
            rules_predicted = 0;
            longest_run     = 0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        function void set_mode(bit cdc);
            cdc_mode = cdc;
        endfunction

        function bit slot_loaded(int s);
            return loaded[s];
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // associativity of upper operator over lower, with null-rejection escapes
        function bit assoc_holds(int up, int low, logic [31:0] shared);
            cat_t uc = category[up];
            cat_t lc = category[low];
            bit   un = |(null_reject[up] & shared);
            bit   ln = |(null_reject[low] & shared);
            if (uc == CAT_JOIN && lc != CAT_FOUTER) return 1'b1;
            if ((uc == CAT_LOUTER || uc == CAT_FOUTER) && lc == CAT_LOUTER) return ln;
            if (uc == CAT_FOUTER && lc == CAT_FOUTER) return un && ln;
            return 1'b0;
        endfunction

        // left or right asscom of upper operator over lower
        function bit asscom_holds(bit on_right, int up, int low, logic [31:0] e1,
                                  logic [31:0] e3);
            cat_t uc = category[up];
            cat_t lc = category[low];
            if (on_right) begin
                if (uc == CAT_JOIN && lc == CAT_JOIN) return 1'b1;
                if (uc == CAT_FOUTER && lc == CAT_FOUTER)
                    return |(null_reject[up] & e3) && |(null_reject[low] & e3);
                return 1'b0;
            end
            if (uc != CAT_FOUTER && lc != CAT_FOUTER) return 1'b1;
            if (uc == CAT_LOUTER && lc == CAT_FOUTER) return |(null_reject[up] & e1);
            if (uc == CAT_FOUTER && lc == CAT_LOUTER) return |(null_reject[low] & e3);
            if (uc == CAT_FOUTER && lc == CAT_FOUTER)
                return |(null_reject[up] & e1) && |(null_reject[low] & e1);
            return 1'b0;
        endfunction

        // rule target falls back to the whole side when the predicate misses it
        function logic [31:0] trim_to_pred(logic [31:0] side, logic [31:0] pred);
            return ((side & pred) != '0) ? (side & pred) : side;
        endfunction

        function out_word_t rule_word(logic [31:0] t1, logic [31:0] t2);
            out_word_t r;
            r                  = '0;
            r.rec.record_type  = 1'b1;
            r.rec.rule_trigger = t1;
            r.rec.rule_target  = t2;
            return r;
        endfunction

        function void note_input(op_word_t w);
            logic [2:0]  jk;
            logic [1:0]  st;
            bit          swap;
            cat_t        c;
            logic [2:0]  okd;
            logic [1:0]  ostr;
            int          b;
            logic [31:0] bl, br, brel, tes, req, al, ar, arel, fta;
            out_word_t   desc;
            out_word_t   rules [$];
            b = int'(w.slot);
            case (w.kind)
                ITEM_CLEAR: begin
                    foreach (loaded[i]) loaded[i] = 1'b0;
                end
                ITEM_LOAD: begin
                    jk   = (w.join_kind > JK_COMMA) ? JK_INNER : w.join_kind;
                    st   = w.join_strictness;
                    swap = 1'b0;
                    ostr = ST_ALL;
                    if (st == ST_SEMI || st == ST_ANTI) begin
                        c    = (st == ST_SEMI) ? CAT_SEMI : CAT_ANTI;
                        swap = (jk == JK_RIGHT);
                        okd  = JK_LEFT;
                        ostr = st;
                    end else if (jk == JK_LEFT || jk == JK_RIGHT) begin
                        c    = CAT_LOUTER;
                        swap = (jk == JK_RIGHT);
                        okd  = JK_LEFT;
                    end else if (jk == JK_FULL) begin
                        c   = CAT_FOUTER;
                        okd = JK_FULL;
                    end else begin
                        c   = CAT_JOIN;
                        okd = jk;
                    end
                    loaded[b]         = 1'b1;
                    category[b]       = c;
                    left_side[b]      = swap ? w.right_rels : w.left_rels;
                    right_side[b]     = swap ? w.left_rels : w.right_rels;
                    pred_mask[b]      = w.pred_rels;
                    null_reject[b]    = w.null_reject_rels;
                    out_kind[b]       = okd;
                    out_strictness[b] = ostr;
                end
                ITEM_QUERY: begin
                    if (!loaded[b]) return;
                    bl   = left_side[b];
                    br   = right_side[b];
                    brel = bl | br;
                    tes  = pred_mask[b] & brel;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (i == b || !loaded[i]) continue;
                        al   = left_side[i];
                        ar   = right_side[i];
                        arel = al | ar;
                        fta  = pred_mask[i];
                        if ((arel & ~bl) == '0) begin
                            if (!assoc_holds(i, b, ar)) begin
                                if (cdc_mode) rules = {rules, rule_word(ar, trim_to_pred(al, fta))};
                                else tes |= al;
                            end
                            if (!asscom_holds(1'b0, i, b, al, br)) begin
                                if (cdc_mode) rules = {rules, rule_word(al, trim_to_pred(ar, fta))};
                                else tes |= ar;
                            end
                        end else if ((arel & ~br) == '0) begin
                            if (!assoc_holds(b, i, al)) begin
                                if (cdc_mode) rules = {rules, rule_word(al, trim_to_pred(ar, fta))};
                                else tes |= ar;
                            end
                            if (!asscom_holds(1'b1, b, i, '0, ar)) begin
                                if (cdc_mode) rules = {rules, rule_word(ar, trim_to_pred(al, fta))};
                                else tes |= al;
                            end
                        end
                    end
                    req = cdc_mode ? (pred_mask[b] & brel) : tes;
                    desc                       = '0;
                    desc.rec.op_relations      = brel;
                    desc.rec.op_left_relations = bl;
                    desc.rec.req_left          = req & bl;
                    desc.rec.req_right         = req & br;
                    desc.rec.pred_rels_out     = pred_mask[b];
                    desc.rec.norm_kind         = out_kind[b];
                    desc.rec.norm_strictness   = out_strictness[b];
                    desc.rec.free_reorder      = (category[b] == CAT_JOIN);
                    desc.last                  = (rules.size() == 0);
                    expected_words = {expected_words, desc};
                    foreach (rules[k]) begin
                        rules[k].last = (k == rules.size() - 1);
                        expected_words = {expected_words, rules[k]};
                    end
                    rules_predicted += rules.size();
                    if (rules.size() + 1 > longest_run) longest_run = rules.size() + 1;
                end
                default: ;
            endcase
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                note_mismatch($sformatf("word %0d, %s: expected %h, got %h",
                                        words_checked, name, want, got));
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            words_checked++;
            if (expected_words.size() == 0) begin
                note_mismatch($sformatf("word %0d arrived with nothing expected",
                                        words_checked));
                return;
            end
            want = expected_words.pop_front();
            match_field("record_type", 32'(want.rec.record_type),
                        32'(got.rec.record_type));
            match_field("op_relations", want.rec.op_relations, got.rec.op_relations);
            match_field("op_left_relations", want.rec.op_left_relations,
                        got.rec.op_left_relations);
            match_field("req_left", want.rec.req_left, got.rec.req_left);
            match_field("req_right", want.rec.req_right, got.rec.req_right);
            match_field("pred_rels_out", want.rec.pred_rels_out, got.rec.pred_rels_out);
            match_field("norm_kind", 32'(want.rec.norm_kind), 32'(got.rec.norm_kind));
            match_field("norm_strictness", 32'(want.rec.norm_strictness),
                        32'(got.rec.norm_strictness));
            match_field("free_reorder", 32'(want.rec.free_reorder),
                        32'(got.rec.free_reorder));
            match_field("rule_trigger", want.rec.rule_trigger, got.rec.rule_trigger);
            match_field("rule_target", want.rec.rule_target, got.rec.rule_target);
            match_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

endpackage

// ===== bench/tb_join_reorder_conflict_detector.sv =====
// ----------------------------------------------------------------------------
// tb_join_reorder_conflict_detector
// self-checking bench for the join reorder conflict detector: a directed
// sequence fills the table for the longest query run, then nested operator
// sets with random content exercise both detection modes under random
// backpressure, checked word by word against the table model
// ----------------------------------------------------------------------------
module tb_join_reorder_conflict_detector;
    import jrcd_pkg::*;
    import jrcd_check_pkg::*;

    localparam int CYCLE_LIMIT      = 800_000;
    // long enough for the slowest query to finish, so the block goes quiet after the last word
    localparam int QUERY_LATENCY    = 100;
    localparam int RANDOM_PER_PHASE = 70;
    localparam int HOLD_CYCLES      = 300;

    // codes outside the documented ranges, folded by the block
    localparam logic [2:0] JK_UNUSED_6 = 3'd6;
    localparam logic [2:0] JK_UNUSED_7 = 3'd7;
    localparam logic [1:0] ST_UNUSED   = 2'd3;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind             = '0;
    logic [3:0]  s_slot             = '0;
    logic [2:0]  s_join_kind        = '0;
    logic [1:0]  s_join_strictness  = '0;
    logic [31:0] s_left_rels        = '0;
    logic [31:0] s_right_rels       = '0;
    logic [31:0] s_pred_rels        = '0;
    logic [31:0] s_null_reject_rels = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_record_type;
    logic [31:0] m_op_relations;
    logic [31:0] m_op_left_relations;
    logic [31:0] m_req_left;
    logic [31:0] m_req_right;
    logic [31:0] m_pred_rels_out;
    logic [2:0]  m_norm_kind;
    logic [1:0]  m_norm_strictness;
    logic        m_free_reorder;
    logic [31:0] m_rule_trigger;
    logic [31:0] m_rule_target;
    logic        m_last;

    conflict_scoreboard sb = new();

    // run statistics for the closing summary
    int cycles    = 0;
    int n_loads   = 0;
    int n_queries = 0;
    int n_clears  = 0;
    int n_ignored = 0;
    int tx_words  = 0;
    int rx_words  = 0;
    bit tx_burst  = 1'b0;
    bit rx_burst  = 1'b0;

    join_reorder_conflict_detector i_dut (.*);

    always #5 aclk = ~aclk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, sb.pending());
            $display("tb_join_reorder_conflict_detector: done, errors");
            $finish;
        end
    end

    // every accepted result word goes straight to the scoreboard
    always @(posedge aclk) begin : result_monitor
        out_word_t got;
        if (aresetn && m_valid && m_ready) begin
            got.rec.record_type       = m_record_type;
            got.rec.op_relations      = m_op_relations;
            got.rec.op_left_relations = m_op_left_relations;
            got.rec.req_left          = m_req_left;
            got.rec.req_right         = m_req_right;
            got.rec.pred_rels_out     = m_pred_rels_out;
            got.rec.norm_kind         = m_norm_kind;
            got.rec.norm_strictness   = m_norm_strictness;
            got.rec.free_reorder      = m_free_reorder;
            got.rec.rule_trigger      = m_rule_trigger;
            got.rec.rule_target       = m_rule_target;
            got.last                  = m_last;
            sb.check_result(got);
        end
    end

    // result side: random stall per word, burst stretches, and two long
    // hold-offs so queries back up into the input channel
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_words % 50 == 0) rx_burst = ($urandom_range(2) == 0);
            if (rx_words == 60 || rx_words == 260) stall = HOLD_CYCLES;
            else stall = rx_burst ? 0 : $urandom_range(15);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            rx_words++;
        end
    end

    function automatic op_word_t random_word();
        op_word_t w;
        w.kind             = item_kind_t'($urandom_range(3));
        w.slot             = 4'($urandom_range(15));
        w.join_kind        = 3'($urandom_range(7));
        w.join_strictness  = 2'($urandom_range(3));
        w.left_rels        = $urandom;
        w.right_rels       = $urandom;
        w.pred_rels        = $urandom;
        w.null_reject_rels = $urandom;
        return w;
    endfunction

    function automatic op_word_t word_of(item_kind_t kind, logic [3:0] slot,
                                         logic [2:0] jk, logic [1:0] st,
                                         logic [31:0] l, logic [31:0] r,
                                         logic [31:0] p, logic [31:0] n);
        op_word_t w;
        w.kind             = kind;
        w.slot             = slot;
        w.join_kind        = jk;
        w.join_strictness  = st;
        w.left_rels        = l;
        w.right_rels       = r;
        w.pred_rels        = p;
        w.null_reject_rels = n;
        return w;
    endfunction

    // a small random set of relations, so operators nest inside each other
    function automatic logic [31:0] pick_universe();
        logic [31:0] u;
        u = '0;
        while ($countones(u) < 6) u[$urandom_range(31)] = 1'b1;
        return u;
    endfunction

    // offer one input word; valid stays up across back-to-back words
    task automatic offer(input op_word_t w, output bit counted);
        int gap;
        if (tx_words % 40 == 0) tx_burst = ($urandom_range(3) == 0);
        gap = tx_burst ? 0 : $urandom_range(15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_kind             <= w.kind;
        s_slot             <= w.slot;
        s_join_kind        <= w.join_kind;
        s_join_strictness  <= w.join_strictness;
        s_left_rels        <= w.left_rels;
        s_right_rels       <= w.right_rels;
        s_pred_rels        <= w.pred_rels;
        s_null_reject_rels <= w.null_reject_rels;
        s_valid            <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        tx_words++;
        // words the block simply drops do not count toward a phase
        counted = 1'b1;
        case (w.kind)
            ITEM_CLEAR: n_clears++;
            ITEM_LOAD:  n_loads++;
            ITEM_QUERY: begin
                if (sb.slot_loaded(w.slot)) n_queries++;
                else begin
                    n_ignored++;
                    counted = 1'b0;
                end
            end
            default: begin
                n_ignored++;
                counted = 1'b0;
            end
        endcase
        sb.note_input(w);
    endtask

    task automatic write_mode(input bit cdc);
        cfg_data  <= cdc;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_mode(cdc);
    endtask

    // drop valid, wait for every expected word, then let a trailing query finish
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (QUERY_LATENCY) @(posedge aclk);
    endtask

    // mostly nested operator sets from one universe, some queries steered to
    // loaded slots, plus clears, unknown kinds and unrelated noise loads
    task automatic random_phase(input int n_items);
        logic [31:0] universe;
        op_word_t    w;
        int          done_items;
        int          pick;
        bit          counted;
        universe   = pick_universe();
        done_items = 0;
        while (done_items < n_items) begin
            pick = $urandom_range(99);
            w    = random_word();
            if (pick < 4) begin
                w.kind   = ITEM_CLEAR;
                universe = pick_universe();
            end else if (pick < 8) begin
                w.kind = ITEM_NONE;
            end else if (pick < 13) begin
                w.kind = ITEM_LOAD;
            end else if (pick < 55) begin
                w.kind       = ITEM_LOAD;
                w.left_rels  = universe & $urandom;
                w.right_rels = universe & ~w.left_rels &
                               (($urandom_range(2) == 0) ? 32'hFFFF_FFFF : $urandom);
                w.pred_rels  = ($urandom_range(4) == 0) ? '0 :
                               ((w.left_rels | w.right_rels) & $urandom);
                w.null_reject_rels = universe & $urandom;
                // lean on outer joins, where the null-rejection escapes live
                if ($urandom_range(1)) w.join_kind = $urandom_range(1) ? JK_FULL : JK_LEFT;
                if ($urandom_range(3) != 0) w.join_strictness = ST_ALL;
            end else begin
                w.kind = ITEM_QUERY;
                for (int t = 0; t < 3 && !sb.slot_loaded(w.slot); t++)
                    w.slot = 4'($urandom_range(15));
            end
            offer(w, counted);
            if (counted) done_items++;
        end
    endtask

    initial begin : stimulus
        op_word_t   w;
        logic [2:0] jk;
        bit         counted;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part runs with rule output on
        write_mode(1'b1);

        // unknown item kind
        w      = random_word();
        w.kind = ITEM_NONE;
        offer(w, counted);

        // full outer join spanning every relation, then fifteen inner-type joins
        // nested in its left side: two rules each, the longest possible run
        offer(word_of(ITEM_LOAD, 4'd0, JK_FULL, ST_ALL, 32'h0000_FFFF, 32'hFFFF_0000,
                      32'h0001_0001, 32'h0001_0001), counted);
        for (int i = 1; i < NUM_SLOTS; i++) begin
            case (i % 5)
                0:       jk = JK_INNER;
                1:       jk = JK_CROSS;
                2:       jk = JK_COMMA;
                3:       jk = JK_UNUSED_6;
                default: jk = JK_UNUSED_7;
            endcase
            // odd slots: predicate meets the side; even slots: empty predicate
            offer(word_of(ITEM_LOAD, 4'(i), jk, i[0] ? ST_UNUSED : ST_ALL,
                          32'h1 << (i - 1), 32'h1 << i,
                          i[0] ? (32'h1 << (i - 1)) : '0, '0), counted);
        end
        offer(word_of(ITEM_QUERY, 4'd0, JK_UNUSED_7, ST_UNUSED, '1, '1, '1, '1), counted);

        // right outer with all-ones extremes, semi, right anti, full with odd strictness
        offer(word_of(ITEM_LOAD, 4'd1, JK_RIGHT, ST_ALL, 32'hFFFF_FFFF, '0,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF), counted);
        offer(word_of(ITEM_LOAD, 4'd2, JK_LEFT, ST_SEMI, 32'h3, 32'h4, 32'h7, 32'h1),
              counted);
        offer(word_of(ITEM_LOAD, 4'd3, JK_RIGHT, ST_ANTI, 32'h30, 32'hC0, '0, '0), counted);
        offer(word_of(ITEM_LOAD, 4'd4, JK_FULL, ST_UNUSED, 32'h100, 32'h200, 32'h300,
                      32'h300), counted);
        offer(word_of(ITEM_QUERY, 4'd1, JK_INNER, ST_ALL, '0, '0, '0, '0), counted);
        offer(word_of(ITEM_QUERY, 4'd3, JK_INNER, ST_ALL, '0, '0, '0, '0), counted);
        offer(word_of(ITEM_QUERY, 4'd4, JK_INNER, ST_ALL, '0, '0, '0, '0), counted);

        // clear, then a query of a now-empty slot gives nothing
        offer(word_of(ITEM_CLEAR, 4'd9, JK_FULL, ST_ANTI, '1, '1, '1, '1), counted);
        offer(word_of(ITEM_QUERY, 4'd0, JK_INNER, ST_ALL, '0, '0, '0, '0), counted);

        // random phases alternate between widening the required set and rule output
        for (int p = 0; p < 4; p++) begin
            settle();
            write_mode(p[0]);
            random_phase(RANDOM_PER_PHASE);
        end
        settle();

        $display("covered %0d loads, %0d live queries, %0d clears, %0d dropped words",
                 n_loads, n_queries, n_clears, n_ignored);
        $display("%0d result words checked in both modes, %0d rules, longest run %0d",
                 sb.words_checked, sb.rules_predicted, sb.longest_run);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_join_reorder_conflict_detector: done, clean");
        end else begin
            $display("%0d mismatches, %0d words never arrived", sb.mismatches, sb.pending());
            $display("tb_join_reorder_conflict_detector: done, errors");
        end
        $finish;
    end

endmodule
